@@ hw/rtl/three_level_priority_fifo_macros.svh @@
// assertion macros shared by the priority queue modules
`ifndef THREE_LEVEL_PRIORITY_FIFO_MACROS_SVH
`define THREE_LEVEL_PRIORITY_FIFO_MACROS_SVH

`ifndef ASSERT_OFF
`define TLPF_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
`define TLPF_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define TLPF_ASSERT_IMP(label, clk, rstn, pre, post)
`define TLPF_ASSERT_NXT(label, clk, rstn, pre, post)
`endif

`endif

@@ hw/rtl/tlpf_pkg.sv @@
// shared constants and types for the three-level priority queue
package tlpf_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_LEVELS      = 3;
    localparam int DEF_ID_BITS     = 16;

    localparam int ID_W     = 16;
    localparam int PRIO_W   = 2;
    localparam int BURST_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 2;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;

    localparam int OUTQ_DEPTH = 3;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                valid;
        logic                hit;
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  level;
    } tlpf_rsp_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  level;
        logic [ID_W-1:0]     id;
        logic [BURST_W-1:0]  burst;
    } tlpf_res_t;

endpackage

@@ hw/rtl/tlpf_store.sv @@
// job entry memory, one write port and one registered read port
module tlpf_store #(
    parameter int DEPTH  = 48,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/tlpf_ctrl.sv @@
// ring pointers, level counts, priority pick and memory access issue
`include "three_level_priority_fifo_macros.svh"
module tlpf_ctrl
    import tlpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int LEVELS      = DEF_LEVELS,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int ADDR_W      = 6
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_tuser,
    input  logic [S_DATA_W-1:0]     s_tdata,
    input  logic                    can_take,
    output logic                    mem_we,
    output logic [ADDR_W-1:0]       mem_waddr,
    output logic [ID_BITS+BURST_W-1:0] mem_wdata,
    output logic                    mem_re,
    output logic [ADDR_W-1:0]       mem_raddr,
    output tlpf_rsp_t               rsp
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W = $clog2(LEVELS);

    logic [PTR_W-1:0] wp_reg [LEVELS];
    logic [PTR_W-1:0] wp_next [LEVELS];
    logic [PTR_W-1:0] rp_reg [LEVELS];
    logic [PTR_W-1:0] rp_next [LEVELS];
    logic [CNT_W-1:0] cnt_reg [LEVELS];
    logic [CNT_W-1:0] cnt_next [LEVELS];
    tlpf_rsp_t        rsp_reg;
    tlpf_rsp_t        rsp_next;

    logic              accept;
    logic [ID_W-1:0]   id_in;
    logic [PRIO_W-1:0] prio_in;
    logic [BURST_W-1:0] burst_in;
    logic [31:0]       prio_w;
    logic [31:0]       id_w;
    logic [LVL_W-1:0]  lvl_enq;
    logic [LVL_W-1:0]  lvl_deq;
    logic              found;
    logic              full;
    logic [PTR_W-1:0]  wp_sel;
    logic [PTR_W-1:0]  rp_sel;

    assign s_tready = can_take;
    assign accept   = s_tvalid && s_tready;
    assign id_in    = s_tdata[ID_W-1:0];
    assign prio_in  = s_tdata[ID_W+PRIO_W-1:ID_W];
    assign burst_in = s_tdata[ID_W+PRIO_W+BURST_W-1:ID_W+PRIO_W];
    assign prio_w   = 32'(prio_in);
    assign id_w     = 32'(id_in);
    assign lvl_enq  = (prio_w >= LEVELS) ? '0 : prio_w[LVL_W-1:0];
    assign full     = (cnt_reg[lvl_enq] == CNT_W'(QUEUE_DEPTH));
    assign wp_sel   = wp_reg[lvl_enq];
    assign rp_sel   = rp_reg[lvl_deq];

    always_comb begin
        found   = 1'b0;
        lvl_deq = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (cnt_reg[i] != '0) begin
                found   = 1'b1;
                lvl_deq = LVL_W'(i);
            end
        end
    end

    assign mem_we    = accept && (s_tuser == MODE_ENQ) && !full;
    assign mem_re    = accept && (s_tuser == MODE_DEQ) && found;
    assign mem_waddr = ADDR_W'(lvl_enq) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wp_sel);
    assign mem_raddr = ADDR_W'(lvl_deq) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rp_sel);
    assign mem_wdata = {burst_in, id_w[ID_BITS-1:0]};

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            wp_next[i]  = wp_reg[i];
            rp_next[i]  = rp_reg[i];
            cnt_next[i] = cnt_reg[i];
        end
        if (mem_we) begin
            wp_next[lvl_enq]  = (wp_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_sel + 1'b1;
            cnt_next[lvl_enq] = cnt_reg[lvl_enq] + 1'b1;
        end
        if (mem_re) begin
            rp_next[lvl_deq]  = (rp_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_sel + 1'b1;
            cnt_next[lvl_deq] = cnt_reg[lvl_deq] - 1'b1;
        end
    end

    always_comb begin
        rsp_next.valid  = accept;
        rsp_next.hit    = mem_re;
        rsp_next.status = ST_OK;
        rsp_next.level  = '0;
        if (s_tuser == MODE_ENQ) begin
            rsp_next.level = LEVEL_W'(lvl_enq);
            if (full) begin
                rsp_next.status = ST_FULL;
            end
        end else if (found) begin
            rsp_next.level = LEVEL_W'(lvl_deq);
        end else begin
            rsp_next.status = ST_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                wp_reg[i]  <= '0;
                rp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
            rsp_reg <= '0;
        end else begin
            for (int i = 0; i < LEVELS; i++) begin
                wp_reg[i]  <= wp_next[i];
                rp_reg[i]  <= rp_next[i];
                cnt_reg[i] <= cnt_next[i];
            end
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    `TLPF_ASSERT_IMP(a_single_port_use, aclk, aresetn, mem_we, !mem_re)
    `TLPF_ASSERT_NXT(a_empty_reply, aclk, aresetn, accept && (s_tuser == MODE_DEQ) && !found, rsp_reg.valid && (rsp_reg.status == ST_EMPTY) && !rsp_reg.hit)
    `TLPF_ASSERT_NXT(a_full_reply, aclk, aresetn, accept && (s_tuser == MODE_ENQ) && full, rsp_reg.valid && (rsp_reg.status == ST_FULL))

endmodule

@@ hw/rtl/tlpf_outq.sv @@
// result assembly and small result queue toward the master side
`include "three_level_priority_fifo_macros.svh"
module tlpf_outq
    import tlpf_pkg::*;
#(
    parameter int ID_BITS = DEF_ID_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tlpf_rsp_t                  rsp,
    input  logic [ID_BITS+BURST_W-1:0] rdata,
    output logic                       can_take,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [STATUS_W-1:0]        m_tuser,
    output logic [M_DATA_W-1:0]        m_tdata
);

    localparam int IDX_W = $clog2(OUTQ_DEPTH);
    localparam int OCC_W = $clog2(OUTQ_DEPTH + 1);

    tlpf_res_t        q_reg [OUTQ_DEPTH];
    logic [IDX_W-1:0] wr_reg;
    logic [IDX_W-1:0] wr_next;
    logic [IDX_W-1:0] rd_reg;
    logic [IDX_W-1:0] rd_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    logic             pop;
    logic [31:0]      rd_id_w;
    tlpf_res_t        res;
    tlpf_res_t        head;
    logic [OCC_W:0]   pending;

    assign rd_id_w = 32'(rdata[ID_BITS-1:0]);

    always_comb begin
        res.status = rsp.status;
        res.level  = rsp.level;
        res.id     = rsp.hit ? rd_id_w[ID_W-1:0] : '0;
        res.burst  = rsp.hit ? rdata[ID_BITS+BURST_W-1:ID_BITS] : '0;
    end

    assign pending  = (OCC_W+1)'(occ_reg) + (OCC_W+1)'(rsp.valid);
    assign can_take = (pending < (OCC_W+1)'(OUTQ_DEPTH));

    assign m_tvalid = (occ_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign head     = q_reg[rd_reg];
    assign m_tuser  = head.status;
    assign m_tdata  = {{(M_DATA_W-ID_W-LEVEL_W-BURST_W){1'b0}}, head.burst, head.level, head.id};

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        occ_next = occ_reg;
        if (rsp.valid) begin
            wr_next = (wr_reg == IDX_W'(OUTQ_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == IDX_W'(OUTQ_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (rsp.valid && !pop) begin
            occ_next = occ_reg + 1'b1;
        end else if (!rsp.valid && pop) begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp.valid) begin
            q_reg[wr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            occ_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            occ_reg <= occ_next;
        end
    end

    `TLPF_ASSERT_IMP(a_no_overflow, aclk, aresetn, rsp.valid, occ_reg != OCC_W'(OUTQ_DEPTH))

endmodule

@@ hw/rtl/three_level_priority_fifo.sv @@
// an accepted request has its reply and memory read registered, then its result written into the result queue
// throughput: one request per cycle while s_tready is high, set by the single access per cycle to the entry memory
// the result queue holds three results, input stalls once three wait or are in flight
// reset: aresetn synchronous, clears pointers, level counts and the result queue
// the entry memory is not cleared, only written entries are ever read
module three_level_priority_fifo
    import tlpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int LEVELS      = DEF_LEVELS,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,   // mode
    input  logic [S_DATA_W-1:0] s_tdata,   // proc_id_in, priority_in, burst_in, zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STATUS_W-1:0] m_tuser,   // status
    output logic [M_DATA_W-1:0] m_tdata    // proc_id_out, level_out, burst_out, zero pad
);

    localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int MEM_W     = ID_BITS + BURST_W;

    logic              can_take;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [MEM_W-1:0]  mem_rdata;
    tlpf_rsp_t         rsp;

    tlpf_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LEVELS      (LEVELS),
        .ID_BITS     (ID_BITS),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .can_take  (can_take),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .rsp       (rsp)
    );

    tlpf_store #(
        .DEPTH  (MEM_DEPTH),
        .WIDTH  (MEM_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tlpf_outq #(
        .ID_BITS (ID_BITS)
    ) u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rsp      (rsp),
        .rdata    (mem_rdata),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

@@ test/tb_top.sv @@
// testbench for the three-level strict-priority job queue with self-checking scoreboard
`timescale 1ns / 1ps

module tb_top
    import tlpf_pkg::*;
();

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 1925;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 300;
    localparam int ENQ_BIAS [4] = '{15, 50, 85, 97};
    localparam int ID_LO        = 0;
    localparam int LEVEL_LO     = ID_W;
    localparam int BURST_LO     = ID_W + LEVEL_W;
    localparam int S_PAD_W      = S_DATA_W - ID_W - PRIO_W - BURST_W;

    class job_queue_scoreboard;
        logic [ID_W-1:0]    id_mem    [DEF_LEVELS][DEF_QUEUE_DEPTH];
        logic [BURST_W-1:0] burst_mem [DEF_LEVELS][DEF_QUEUE_DEPTH];
        int unsigned        head      [DEF_LEVELS];
        int unsigned        tail      [DEF_LEVELS];
        int unsigned        fill      [DEF_LEVELS];
        tlpf_res_t          pending_results [$];
        int                 errors;

        function new();
            for (int l = 0; l < DEF_LEVELS; l++) begin
                head[l] = 0;
                tail[l] = 0;
                fill[l] = 0;
            end
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void take_request(logic mode, logic [ID_W-1:0] id,
                                   logic [PRIO_W-1:0] prio, logic [BURST_W-1:0] burst);
            tlpf_res_t res;
            int        lvl;
            bit        found;
            res = '0;
            res.status = ST_OK;
            if (mode == MODE_ENQ) begin
                lvl = (prio >= DEF_LEVELS) ? 0 : int'(prio);
                res.level = lvl[LEVEL_W-1:0];
                if (fill[lvl] >= DEF_QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    id_mem[lvl][tail[lvl]]    = id;
                    burst_mem[lvl][tail[lvl]] = burst;
                    tail[lvl] = (tail[lvl] + 1) % DEF_QUEUE_DEPTH;
                    fill[lvl]++;
                end
            end else begin
                found = 1'b0;
                for (int l = 0; l < DEF_LEVELS; l++) begin
                    if (!found && fill[l] != 0) begin
                        found = 1'b1;
                        lvl = l;
                    end
                end
                if (!found) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.id    = id_mem[lvl][head[lvl]];
                    res.burst = burst_mem[lvl][head[lvl]];
                    res.level = lvl[LEVEL_W-1:0];
                    head[lvl] = (head[lvl] + 1) % DEF_QUEUE_DEPTH;
                    fill[lvl]--;
                end
            end
            pending_results.push_back(res);
        endfunction

        function void match_result(tlpf_res_t got);
            tlpf_res_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d id %0h level %0d burst %0h",
                       got.status, got.id, got.level, got.burst);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.id !== want.id) begin
                $error("proc_id_out: expected %0h, actual %0h", want.id, got.id);
                errors++;
            end
            if (got.level !== want.level) begin
                $error("level_out: expected %0d, actual %0d", want.level, got.level);
                errors++;
            end
            if (got.burst !== want.burst) begin
                $error("burst_out: expected %0h, actual %0h", want.burst, got.burst);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic                s_tuser;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [STATUS_W-1:0] m_tuser;
    logic [M_DATA_W-1:0] m_tdata;

    job_queue_scoreboard sb;
    bit                  no_idle = 1'b0;
    int                  stall_ask = 0;
    int                  cycle_count = 0;

    three_level_priority_fifo u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_request(input logic mode, input logic [ID_W-1:0] id,
                                input logic [PRIO_W-1:0] prio, input logic [BURST_W-1:0] burst);
        while (!no_idle && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{S_PAD_W{1'b0}}, burst, prio, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_request(mode, id, prio, burst);
    endtask

    // result side: random backpressure plus one long hold on request
    initial begin : result_sink
        int        hold;
        int        seen;
        tlpf_res_t got;
        hold = 0;
        seen = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.id     = m_tdata[ID_LO +: ID_W];
                got.level  = m_tdata[LEVEL_LO +: LEVEL_W];
                got.burst  = m_tdata[BURST_LO +: BURST_W];
                sb.match_result(got);
            end
            if (stall_ask != seen) begin
                seen = stall_ask;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= 31);
            end
        end
    end

    initial begin : request_source
        int                 enq_pct;
        int                 focus;
        logic               mode;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = MODE_ENQ;
        s_tdata  = '0;
        m_tready = 1'b0;
        enq_pct  = ENQ_BIAS[1];
        focus    = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // dequeue with every level empty
        send_request(MODE_DEQ, '0, '0, '0);
        send_request(MODE_ENQ, '0, 2'd0, '0);
        // out-of-range priority goes to level 0
        send_request(MODE_ENQ, '1, 2'd3, '1);
        send_request(MODE_ENQ, 16'h1234, 2'd2, 32'h7f80_0000);
        // fill level 1, then one refused request
        for (int i = 0; i <= DEF_QUEUE_DEPTH; i++) begin
            send_request(MODE_ENQ, 16'h0a00 + i[ID_W-1:0], 2'd1, $urandom());
        end
        repeat (4) send_request(MODE_DEQ, ID_W'($urandom()), PRIO_W'($urandom()), $urandom());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                enq_pct = ENQ_BIAS[$urandom_range(3)];
                focus   = $urandom_range(3);
            end
            if (n == 500) no_idle = 1'b1;
            if (n == 800) no_idle = 1'b0;
            if (n == 1000) stall_ask++;
            if (n == 1400) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
            end
            mode  = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
            prio  = $urandom_range(1) ? focus[PRIO_W-1:0] : PRIO_W'($urandom_range(3));
            id    = ID_W'($urandom());
            burst = $urandom();
            if ($urandom_range(9) == 0) id = $urandom_range(1) ? '1 : '0;
            if ($urandom_range(9) == 0) burst = $urandom_range(1) ? '1 : '0;
            send_request(mode, id, prio, burst);
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ three_level_priority_fifo.f @@
+incdir+hw/rtl
hw/rtl/tlpf_pkg.sv
hw/rtl/tlpf_store.sv
hw/rtl/tlpf_ctrl.sv
hw/rtl/tlpf_outq.sv
hw/rtl/three_level_priority_fifo.sv
test/tb_top.sv
